[design/fsfd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsfd_pkg: shared types and constants for the force sensor frame decoder
// Frame layout, request structs, calibration constants and the coefficient
// builder evaluated at elaboration.
// ----------------------------------------------------------------------------
package fsfd_pkg;

    localparam int NUM_CH = 6;
    localparam int CH_W   = 3;

    localparam logic [7:0] HDR0 = 8'hAA;
    localparam logic [7:0] HDR1 = 8'h55;

    // byte positions within a frame
    localparam logic [4:0] POS_HDR0       = 5'd0;
    localparam logic [4:0] POS_HDR1       = 5'd1;
    localparam logic [4:0] POS_DATA_FIRST = 5'd6;
    localparam logic [4:0] POS_DATA_LAST  = 5'd17;
    localparam logic [4:0] POS_CHECK      = 5'd18;
    localparam logic [4:0] FRAME_LEN      = 5'd19;

    localparam logic [CH_W-1:0] AXIS_LAST = 3'd5;

    localparam logic [15:0] OFFSET_RESET [NUM_CH] = '{
        16'd32715, 16'd32693, 16'd32689, 16'd32681, 16'd32703, 16'd32735
    };

    // decoupling matrix, units of 1e-5
    localparam int DEC_E5 [NUM_CH][NUM_CH] = '{
        '{71643, 34509, -30487, 4744053, -3246, -4823680},
        '{110584, -5548118, 74791, 2774202, 131624, 2756464},
        '{15475180, -29425, 15429744, -249127, 15461993, 4028},
        '{-4923, -1943, -119667, 1850, 108773, 1559},
        '{133007, -1110, -65628, -682, -62841, 1825},
        '{-990, 44900, 174, 42497, 538, 42179}
    };

    // channel gains, units of 1e-6
    localparam longint unsigned GAIN_E6 [NUM_CH] = '{
        64'd123519878, 64'd123453219, 64'd123580741,
        64'd123490896, 64'd123395254, 64'd123554657
    };

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_start;
    } t_in_req;

    typedef struct packed {
        logic [CH_W-1:0]    axis;
        logic signed [31:0] axis_value;
        logic               last;
    } t_out_req;

    typedef struct packed {
        logic [NUM_CH-1:0][15:0] sample;
        logic [NUM_CH-1:0][15:0] offset;
    } t_frame_job;

    // Coefficient d * 5000 / (65535 * g * 2.503526) in Q(frac_bits),
    // magnitude rounded half away from zero. Long division by shift-subtract;
    // the numerator is always below the denominator.
    function automatic longint coef_value(input int row, input int col,
                                          input int frac_bits);
        longint          d;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned rem;
        longint unsigned quo;
        int              n;
        d   = longint'(DEC_E5[row][col]);
        mag = (d < 0) ? longint'(-d) : d;
        mag = mag * 64'd5000000000;
        den = 64'd13107 * GAIN_E6[col] * 64'd1251763;
        rem = mag;
        quo = 64'd0;
        for (n = 0; n <= frac_bits; n++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        quo = (quo + 64'd1) >> 1;
        return (d < 0) ? -longint'(quo) : longint'(quo);
    endfunction

endpackage
`default_nettype wire

[design/force_sensor_frame_decouple_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// force_sensor_frame_decouple_unit: six-axis force/torque frame decoder
// Parses 19-byte sensor frames and applies the folded calibration matrix.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in_req  (frame_byte, frame_start)
//  out       output     o_out_valid / i_out_ready  o_out_req (axis, axis_value, last)
//  cfg       input      i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
//  A byte is taken whenever the job queue has room; the parser never stalls
//  otherwise. For a good frame the matrix engine runs, per axis, six
//  multiply-accumulate issues through one shared multiplier, a pipeline flush
//  and rounding. Reset is synchronous, active low, and restores offsets and
//  the idle parser. A stalled output holds the engine; the two-entry queue keeps
//  the parser taking bytes until both entries are occupied.
// ----------------------------------------------------------------------------
module force_sensor_frame_decouple_unit #(
    parameter int COEF_FRAC_BITS = 30,
    parameter int OUT_FRAC_BITS  = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  fsfd_pkg::t_in_req   i_in_req,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output fsfd_pkg::t_out_req  o_out_req,
    input  wire                 i_cfg_we,
    input  wire  [2:0]          i_cfg_idx,
    input  wire  [15:0]         i_cfg_data
);

    fsfd_pkg::t_frame_job w_push_job;
    fsfd_pkg::t_frame_job w_head_job;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_full;
    logic                 w_not_empty;

    // front: accept bytes, check header and checksum, push good frames
    fsfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (w_full),
        .o_q_push   (w_push),
        .o_q_job    (w_push_job)
    );

    // hold finished frames so each side can stall on its own
    fsfd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_job       (w_push_job),
        .i_pop       (w_pop),
        .o_job       (w_head_job),
        .o_full      (w_full),
        .o_not_empty (w_not_empty)
    );

    // back: run the matrix and deliver six axis results per frame
    fsfd_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .OUT_FRAC_BITS  (OUT_FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (w_not_empty),
        .i_q_job       (w_head_job),
        .o_q_pop       (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_req     (o_out_req)
    );

endmodule
`default_nettype wire

[design/fsfd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsfd_front: frame byte parser
// Tracks the byte position, checks header and checksum, gathers the six
// samples and hands a complete good frame to the job queue.
// ----------------------------------------------------------------------------
module fsfd_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  fsfd_pkg::t_in_req     i_in_req,
    input  wire                   i_cfg_we,
    input  wire  [2:0]            i_cfg_idx,
    input  wire  [15:0]           i_cfg_data,
    input  wire                   i_q_full,
    output logic                  o_q_push,
    output fsfd_pkg::t_frame_job  o_q_job
);

    logic [4:0]  r_pos;
    logic        r_hdr_good;
    logic [7:0]  r_sum;
    logic [7:0]  r_high;
    logic [15:0] r_sample [fsfd_pkg::NUM_CH];
    logic [15:0] r_offset [fsfd_pkg::NUM_CH];

    logic       w_accept;
    logic [4:0] w_pos;
    logic [4:0] w_sidx;

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pos      = i_in_req.frame_start ? fsfd_pkg::POS_HDR0 : r_pos;
    assign w_sidx     = (w_pos - 5'd7) >> 1;

    assign o_q_push = w_accept && (w_pos == fsfd_pkg::POS_CHECK) && r_hdr_good
                      && (r_sum == i_in_req.frame_byte);

    always_comb begin
        for (int c = 0; c < fsfd_pkg::NUM_CH; c++) begin
            o_q_job.sample[c] = r_sample[c];
            o_q_job.offset[c] = r_offset[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= fsfd_pkg::FRAME_LEN;
            r_hdr_good <= 1'b0;
            r_sum      <= 8'd0;
            r_high     <= 8'd0;
            for (int c = 0; c < fsfd_pkg::NUM_CH; c++) begin
                r_offset[c] <= fsfd_pkg::OFFSET_RESET[c];
            end
        end else begin
            if (i_cfg_we && (int'(i_cfg_idx) < fsfd_pkg::NUM_CH)) begin
                r_offset[i_cfg_idx] <= i_cfg_data;
            end
            if (w_accept && (w_pos < fsfd_pkg::FRAME_LEN)) begin
                r_pos <= w_pos + 5'd1;
                if (w_pos == fsfd_pkg::POS_HDR0) begin
                    r_hdr_good <= (i_in_req.frame_byte == fsfd_pkg::HDR0);
                    r_sum      <= 8'd0;
                end else if (w_pos == fsfd_pkg::POS_HDR1) begin
                    r_hdr_good <= r_hdr_good && (i_in_req.frame_byte == fsfd_pkg::HDR1);
                end else if ((w_pos >= fsfd_pkg::POS_DATA_FIRST)
                             && (w_pos <= fsfd_pkg::POS_DATA_LAST)) begin
                    r_sum <= r_sum + i_in_req.frame_byte;
                    if (!w_pos[0]) begin
                        r_high <= i_in_req.frame_byte;
                    end
                end
            end
        end
    end

    // sample store: written once per frame before the job is taken
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_pos >= fsfd_pkg::POS_DATA_FIRST)
            && (w_pos <= fsfd_pkg::POS_DATA_LAST) && w_pos[0]) begin
            r_sample[w_sidx[2:0]] <= {r_high, i_in_req.frame_byte};
        end
    end

endmodule
`default_nettype wire

[design/fsfd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsfd_queue: two-entry job queue
// Holds finished frames between parser and matrix engine.
// ----------------------------------------------------------------------------
module fsfd_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  fsfd_pkg::t_frame_job  i_job,
    input  wire                   i_pop,
    output fsfd_pkg::t_frame_job  o_job,
    output logic                  o_full,
    output logic                  o_not_empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    fsfd_pkg::t_frame_job r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [PTR_W:0]       r_count;

    assign o_full      = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[design/fsfd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsfd_back: calibration matrix engine
// One pipelined multiply-accumulate walks the six terms of each axis, 36 per
// frame; each axis is then rounded, saturated and placed in the output register.
// ----------------------------------------------------------------------------
module fsfd_back #(
    parameter int COEF_FRAC_BITS = 30,
    parameter int OUT_FRAC_BITS  = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_q_not_empty,
    input  fsfd_pkg::t_frame_job  i_q_job,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output fsfd_pkg::t_out_req    o_out_req
);

    localparam int NCOEF  = fsfd_pkg::NUM_CH * fsfd_pkg::NUM_CH;
    localparam int CIDX_W = $clog2(NCOEF);
    localparam int COEF_W = COEF_FRAC_BITS - 3;
    localparam int PROD_W = COEF_W + 17;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SHIFT  = COEF_FRAC_BITS - OUT_FRAC_BITS;
    localparam int NSHIFT = (SHIFT < 0) ? -SHIFT : 0;
    localparam int CONV_W = ACC_W + 1 + NSHIFT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_FLUSH,
        S_ROUND
    } t_state;

    t_state                     r_state;
    fsfd_pkg::t_frame_job       r_job;
    logic [fsfd_pkg::CH_W-1:0]  r_axis;
    logic [fsfd_pkg::CH_W-1:0]  r_k;
    logic [CIDX_W-1:0]          r_cidx;

    logic                       r_s1_vld, r_s1_first, r_s1_last;
    logic signed [16:0]         r_s1_diff;
    logic signed [COEF_W-1:0]   r_s1_coef;
    logic                       r_s2_vld, r_s2_first, r_s2_last;
    logic signed [PROD_W-1:0]   r_s2_prod;
    logic signed [ACC_W-1:0]    r_acc;

    logic signed [COEF_W-1:0]   w_coef [NCOEF];
    logic signed [CONV_W-1:0]   w_conv;
    logic [CONV_W-32:0]         w_top;
    logic signed [31:0]         w_sat;
    logic                       w_out_free;

    // constant coefficient table
    for (genvar g = 0; g < NCOEF; g++) begin : g_coef
        assign w_coef[g] = COEF_W'(fsfd_pkg::coef_value(g / fsfd_pkg::NUM_CH,
                                                       g % fsfd_pkg::NUM_CH,
                                                       COEF_FRAC_BITS));
    end

    // scale to output fraction bits
    if (SHIFT > 0) begin : g_rshift
        logic signed [ACC_W:0] w_sum;
        assign w_sum  = $signed({r_acc[ACC_W-1], r_acc})
                        + $signed((ACC_W + 1)'(1) << (SHIFT - 1));
        assign w_conv = w_sum >>> SHIFT;
    end else if (SHIFT == 0) begin : g_noshift
        assign w_conv = {r_acc[ACC_W-1], r_acc};
    end else begin : g_lshift
        assign w_conv = {{(CONV_W - ACC_W){r_acc[ACC_W-1]}}, r_acc} << NSHIFT;
    end

    assign w_top = w_conv[CONV_W-1:31];
    assign w_sat = ((&w_top) || !(|w_top)) ? w_conv[31:0]
                 : (w_conv[CONV_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    assign w_out_free = !o_out_valid || i_out_ready;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_k         <= '0;
            r_cidx      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            // drop a taken result; in S_ROUND the state arm decides
            if (o_out_valid && i_out_ready && (r_state != S_ROUND)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_not_empty) begin
                        r_axis  <= '0;
                        r_k     <= '0;
                        r_cidx  <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_cidx <= r_cidx + 1'b1;
                    if (r_k == fsfd_pkg::AXIS_LAST) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_FLUSH: begin
                    if (r_s2_vld && r_s2_last) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (w_out_free) begin
                        o_out_valid          <= 1'b1;
                        o_out_req.axis       <= r_axis;
                        o_out_req.axis_value <= w_sat;
                        o_out_req.last       <= (r_axis == fsfd_pkg::AXIS_LAST);
                        r_k                  <= '0;
                        if (r_axis == fsfd_pkg::AXIS_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= (r_state == S_ISSUE);
            r_s2_vld <= r_s1_vld;
        end
    end

    // datapath: operand fetch, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        r_s1_first <= (r_k == '0);
        r_s1_last  <= (r_k == fsfd_pkg::AXIS_LAST);
        r_s1_diff  <= $signed({1'b0, r_job.sample[r_k]}) - $signed({1'b0, r_job.offset[r_k]});
        r_s1_coef  <= w_coef[r_cidx];
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_prod  <= r_s1_diff * r_s1_coef;
        if (r_s2_vld) begin
            r_acc <= r_s2_first ? ACC_W'(r_s2_prod) : r_acc + ACC_W'(r_s2_prod);
        end
    end

endmodule
`default_nettype wire

[sim/tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for the force sensor frame decoder
// Drives byte requests through the valid/ready input, predicts the six axis
// results of every good frame in fixed point, and checks each output request
// field by field. Directed frames come first, then random traffic under
// three idling mixes, a long receiver hold-off and several offset sets.
// ----------------------------------------------------------------------------
module tb;
    import fsfd_pkg::*;

    localparam int FRAME_BYTES     = 19;
    localparam int COEF_FRAC       = 30;
    localparam int OUT_FRAC        = 16;
    localparam int ROUND_SHIFT     = COEF_FRAC - OUT_FRAC;
    localparam int SETTLE_CYCLES   = 200;
    localparam int HOLD_CYCLES     = 400;
    localparam int PRESSURE_FRAMES = 4;
    localparam int PHASE_BYTES     = 16;
    localparam int MIDCFG_BYTE     = 10;
    localparam int END_WAIT_CYCLES = 20000;
    localparam int RUN_LIMIT       = 4000000;
    localparam int NUM_DIR         = 20;

    // register map: offsets 0..5, indexes 6 and 7 unused
    localparam logic [2:0] REG_OFS_CH0  = 3'd0;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int TX_IDLE_PCT [3] = '{9, 65, 0};
    localparam int RX_IDLE_PCT [3] = '{65, 9, 0};

    // decoupling matrix (1e-5 units) and channel gains (1e-6 units)
    localparam longint DECOUPLE_E5 [6][6] = '{
        '{71643, 34509, -30487, 4744053, -3246, -4823680},
        '{110584, -5548118, 74791, 2774202, 131624, 2756464},
        '{15475180, -29425, 15429744, -249127, 15461993, 4028},
        '{-4923, -1943, -119667, 1850, 108773, 1559},
        '{133007, -1110, -65628, -682, -62841, 1825},
        '{-990, 44900, 174, 42497, 538, 42179}
    };
    localparam longint unsigned CH_GAIN_E6 [6] = '{
        64'd123519878, 64'd123453219, 64'd123580741,
        64'd123490896, 64'd123395254, 64'd123554657
    };
    localparam logic [15:0] OFFSET_DEFAULT [6] = '{
        16'd32715, 16'd32693, 16'd32689, 16'd32681, 16'd32703, 16'd32735
    };
    // the reset offsets as one packed sample set, channel 0 in the low bits
    localparam logic [5:0][15:0] DEFAULT_SAMPLES = {
        16'd32735, 16'd32703, 16'd32681, 16'd32689, 16'd32693, 16'd32715
    };

    typedef enum logic [3:0] {
        FK_GOOD, FK_BAD_HDR0, FK_BAD_HDR1, FK_BAD_SUM, FK_CUT, FK_JUNK,
        FK_MIDCFG, RK_SET_ZERO, RK_SET_MAX, RK_SPARE_IDX
    } step_kind_e;

    // where a frame's results come from: the predictor, nothing, or all zero
    typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_ZERO} axis_expect_e;

    typedef struct packed {
        step_kind_e       kind;
        logic [5:0][15:0] samples;
        logic [4:0]       len;
        axis_expect_e     exp;
    } dir_row_t;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_t;

    // directed frames; typed expectations only where the answer is obvious
    dir_row_t dir_tab [NUM_DIR] = '{
        '{FK_JUNK,      '0,              5'd3,  EXP_NONE},    // bytes before any start
        '{FK_GOOD,      DEFAULT_SAMPLES, 5'd19, EXP_ZERO},    // counts equal to offsets
        '{FK_GOOD,      {16'hFEDC, 16'h0001, 16'h8000, 16'h7FFF, 16'hA5C3, 16'h1234},
                        5'd19, EXP_PREDICT},
        '{FK_BAD_HDR0,  DEFAULT_SAMPLES, 5'd19, EXP_NONE},
        '{FK_BAD_HDR1,  DEFAULT_SAMPLES, 5'd19, EXP_NONE},
        '{FK_BAD_SUM,   DEFAULT_SAMPLES, 5'd19, EXP_NONE},
        '{FK_CUT,       {6{16'h4321}},   5'd11, EXP_NONE},    // restarted mid-frame
        '{FK_GOOD,      {6{16'h9ABC}},   5'd19, EXP_PREDICT},
        '{FK_JUNK,      '0,              5'd4,  EXP_NONE},    // bytes after byte 18
        '{RK_SPARE_IDX, '0,              5'd0,  EXP_NONE},
        '{FK_GOOD,      DEFAULT_SAMPLES, 5'd19, EXP_ZERO},    // spare writes ignored
        '{FK_GOOD,      '0,              5'd19, EXP_PREDICT},
        '{RK_SET_ZERO,  '0,              5'd0,  EXP_NONE},
        '{FK_GOOD,      {6{16'hFFFF}},   5'd19, EXP_PREDICT},
        '{FK_GOOD,      '0,              5'd19, EXP_ZERO},
        '{RK_SET_MAX,   '0,              5'd0,  EXP_NONE},
        '{FK_GOOD,      '0,              5'd19, EXP_PREDICT},
        '{FK_GOOD,      {6{16'hFFFF}},   5'd19, EXP_ZERO},
        '{FK_MIDCFG,    {6{16'hFFFF}},   5'd19, EXP_PREDICT}, // offsets rewritten mid-frame
        '{FK_GOOD,      {3{16'hFFFF, 16'h0000}}, 5'd19, EXP_PREDICT}
    };

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       in_valid = 1'b0;
    t_in_req    in_req   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_we   = 1'b0;
    logic [2:0] cfg_idx  = '0;
    logic [15:0] cfg_data = '0;
    wire        in_ready;
    wire        out_valid;
    t_out_req   out_req;

    // predictor state
    longint       calib_q30 [6][6];
    logic [15:0]  offs [6];
    logic [15:0]  samp [6];
    int unsigned  fr_pos;
    bit           hdr_ok;
    logic [7:0]   chk_sum;
    logic [7:0]   hi_hold;
    axis_expect_e row_expect = EXP_PREDICT;
    t_out_req     axis_expect_q [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_asked  = 0;
    int hold_seen   = 0;
    int hold_len    = 0;
    int hold_left   = 0;

    int mismatch_count = 0;
    int bytes_taken    = 0;
    int axes_checked   = 0;
    int frames_good    = 0;
    int frames_bad     = 0;

    force_sensor_frame_decouple_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_req),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // hard stop in case a handshake never completes
    initial begin
        #(RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Q30 coefficient d*5000/(65535*g*2.503526), magnitude rounded half away
    function automatic longint calib_coef(input int row, input int col);
        longint          d;
        longint unsigned num;
        longint unsigned den;
        longint unsigned rem;
        longint unsigned quo;
        int              n;
        d   = DECOUPLE_E5[row][col];
        num = (d < 0) ? -d : d;
        num = num * 64'd5000000000;
        den = 64'd13107 * CH_GAIN_E6[col] * 64'd1251763;
        rem = num;
        quo = 64'd0;
        // one extra quotient bit drives the rounding
        for (n = 0; n <= COEF_FRAC; n++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        quo = (quo + 64'd1) >> 1;
        return (d < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    // Advance the frame parser by one accepted byte; at byte 18 of a good
    // frame queue the six axis results.
    task automatic decode_frame_byte(input t_in_req rq);
        int unsigned pos;
        logic [7:0]  b;
        longint      acc;
        longint      v;
        t_out_req    r;
        int          i;
        int          k;
        bit          good;
        b = rq.frame_byte;
        if (rq.frame_start) fr_pos = 0;
        pos = fr_pos;
        if (pos >= FRAME_BYTES) return;
        if (pos == 0) begin
            hdr_ok  = (b == HDR0);
            chk_sum = 8'd0;
        end else if (pos == 1) begin
            hdr_ok = hdr_ok && (b == HDR1);
        end else if (pos >= 6 && pos <= 17) begin
            chk_sum = chk_sum + b;
            if (((pos - 6) & 1) == 0) hi_hold = b;
            else samp[(pos - 7) >> 1] = {hi_hold, b};
        end else if (pos == 18) begin
            good = hdr_ok && (chk_sum == b);
            if (good) frames_good++;
            else frames_bad++;
            for (i = 0; i < NUM_CH; i++) begin
                acc = 0;
                for (k = 0; k < NUM_CH; k++) begin
                    acc += (longint'(samp[k]) - longint'(offs[k])) * calib_q30[i][k];
                end
                // round to nearest, ties toward plus infinity, then saturate
                v = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                r.axis       = 3'(i);
                r.axis_value = (row_expect == EXP_ZERO) ? 32'sd0 : 32'(v);
                r.last       = (r.axis == AXIS_LAST);
                if (row_expect == EXP_ZERO || (row_expect == EXP_PREDICT && good)) begin
                    axis_expect_q.push_back(r);
                end
            end
        end
        fr_pos = pos + 1;
    endtask

    // track every byte request the block takes
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            bytes_taken++;
            decode_frame_byte(in_req);
        end
    end

    // check every axis request the block hands out against the oldest one due
    always @(posedge clk) begin : out_check
        t_out_req want;
        if (rst_n && out_valid && out_ready) begin
            if (axis_expect_q.size() == 0) begin
                log_mismatch($sformatf("unexpected result axis %0d value %0d",
                                       out_req.axis, out_req.axis_value));
            end else begin
                want = axis_expect_q.pop_front();
                axes_checked++;
                if (out_req.axis !== want.axis) begin
                    log_mismatch($sformatf("axis got %0d want %0d",
                                           out_req.axis, want.axis));
                end
                if (out_req.axis_value !== want.axis_value) begin
                    log_mismatch($sformatf("axis %0d value got %0d want %0d",
                                           want.axis, out_req.axis_value, want.axis_value));
                end
                if (out_req.last !== want.last) begin
                    log_mismatch($sformatf("axis %0d last got %0b want %0b",
                                           want.axis, out_req.last, want.last));
                end
            end
        end
    end

    // Receiver: stall at the current rate, or hold off for a counted stretch
    // when the stimulus asks for one.
    always @(negedge clk) begin
        if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Drop valid; settling and offset writes start here.
    task automatic tx_rest();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Offer one byte request, idling first at the sender's rate, and hold it
    // until taken. Returns at the accepting edge.
    task automatic send_byte(input logic [7:0] b, input logic st, input axis_expect_e ex);
        @(negedge clk);
        row_expect = ex;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{frame_byte: b, frame_start: st};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Wait until every queued result is out, then let any dropped frame finish.
    task automatic settle_block();
        tx_rest();
        while (axis_expect_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_offset_reg(input logic [2:0] idx, input logic [15:0] val);
        tx_rest();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx < 3'(NUM_CH)) offs[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        @(posedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    task automatic hold_receiver(input int cycles);
        @(posedge clk);
        hold_len   = cycles;
        hold_asked = hold_asked + 1;
    endtask

    function automatic frame_bytes_t build_frame(input logic [5:0][15:0] smp,
                                                 input step_kind_e kind);
        frame_bytes_t fb;
        logic [7:0]   sum;
        int           n;
        sum   = 8'd0;
        fb[0] = HDR0;
        fb[1] = HDR1;
        for (n = 2; n < 6; n++) fb[n] = 8'($urandom_range(255));
        for (n = 0; n < NUM_CH; n++) begin
            fb[6 + 2 * n] = smp[n][15:8];
            fb[7 + 2 * n] = smp[n][7:0];
        end
        for (n = 6; n < 18; n++) sum = sum + fb[n];
        fb[18] = sum;
        case (kind)
            FK_BAD_HDR0: fb[0]  = HDR0 ^ 8'($urandom_range(255, 1));
            FK_BAD_HDR1: fb[1]  = HDR1 ^ 8'($urandom_range(255, 1));
            FK_BAD_SUM:  fb[18] = sum + 8'($urandom_range(255, 1));
            default: ;
        endcase
        return fb;
    endfunction

    // Send the first len bytes of a frame; on request rewrite the offsets
    // partway through, once the block has gone quiet.
    task automatic send_frame(input frame_bytes_t fb, input int len, input bit mid_cfg,
                              input axis_expect_e ex);
        int n;
        int ch;
        for (n = 0; n < len; n++) begin
            if (mid_cfg && n == MIDCFG_BYTE) begin
                settle_block();
                for (ch = 0; ch < NUM_CH; ch++) begin
                    write_offset_reg(REG_OFS_CH0 + 3'(ch), OFFSET_DEFAULT[ch]);
                end
            end
            send_byte(fb[n], n == 0, ex);
        end
    endtask

    task automatic send_junk(input int count, input axis_expect_e ex);
        int n;
        for (n = 0; n < count; n++) send_byte(8'($urandom_range(255)), 1'b0, ex);
    endtask

    function automatic logic [15:0] random_count(input logic [15:0] zero);
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 4) return 16'($urandom_range(65535));
        if (pick < 8) return zero + 16'($urandom_range(4000)) - 16'd2000;
        if (pick < 9) return 16'h0000;
        return 16'hFFFF;
    endfunction

    function automatic logic [15:0] random_offset();
        if ($urandom_range(1) == 1) return 16'd32400 + 16'($urandom_range(600));
        return 16'($urandom_range(65535));
    endfunction

    initial begin : stimulus
        dir_row_t         row;
        logic [5:0][15:0] smp;
        step_kind_e       kind;
        int               r;
        int               ch;
        int               ph;
        int               roll;
        int               len;
        int               counted;
        int               waited;
        for (r = 0; r < NUM_CH; r++) begin
            offs[r] = OFFSET_DEFAULT[r];
            samp[r] = 16'h0000;
            for (ch = 0; ch < NUM_CH; ch++) calib_q30[r][ch] = calib_coef(r, ch);
        end
        fr_pos  = FRAME_BYTES;
        hdr_ok  = 1'b0;
        chk_sum = 8'd0;
        hi_hold = 8'd0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // directed frames, moderate idling on both sides
        set_idling(20, 20);
        for (r = 0; r < NUM_DIR; r++) begin
            row = dir_tab[r];
            case (row.kind)
                RK_SET_ZERO: begin
                    settle_block();
                    for (ch = 0; ch < NUM_CH; ch++) begin
                        write_offset_reg(REG_OFS_CH0 + 3'(ch), 16'h0000);
                    end
                end
                RK_SET_MAX: begin
                    settle_block();
                    for (ch = 0; ch < NUM_CH; ch++) begin
                        write_offset_reg(REG_OFS_CH0 + 3'(ch), 16'hFFFF);
                    end
                end
                RK_SPARE_IDX: begin
                    settle_block();
                    write_offset_reg(REG_SPARE_LO, 16'h0000);
                    write_offset_reg(REG_SPARE_HI, 16'hFFFF);
                end
                FK_JUNK: begin
                    send_junk(int'(row.len), row.exp);
                end
                default: begin
                    len = (row.kind == FK_CUT) ? int'(row.len) : FRAME_BYTES;
                    send_frame(build_frame(row.samples, row.kind), len,
                               row.kind == FK_MIDCFG, row.exp);
                end
            endcase
        end

        // back pressure: hold the receiver off while good frames keep coming,
        // so the job queue fills and the input stalls
        settle_block();
        set_idling(0, 0);
        hold_receiver(HOLD_CYCLES);
        for (r = 0; r < PRESSURE_FRAMES; r++) begin
            for (ch = 0; ch < NUM_CH; ch++) smp[ch] = random_count(offs[ch]);
            send_frame(build_frame(smp, FK_GOOD), FRAME_BYTES, 1'b0, EXP_PREDICT);
        end

        // random traffic: mostly good frames, the rest broken or noise
        for (ph = 0; ph < 3; ph++) begin
            settle_block();
            for (ch = 0; ch < NUM_CH; ch++) begin
                write_offset_reg(REG_OFS_CH0 + 3'(ch), random_offset());
            end
            set_idling(TX_IDLE_PCT[ph], RX_IDLE_PCT[ph]);
            counted = 0;
            while (counted < PHASE_BYTES) begin
                roll = $urandom_range(99);
                if (roll < 72) kind = FK_GOOD;
                else if (roll < 78) kind = FK_BAD_HDR0;
                else if (roll < 83) kind = FK_BAD_HDR1;
                else if (roll < 89) kind = FK_BAD_SUM;
                else if (roll < 95) kind = FK_CUT;
                else kind = FK_JUNK;
                if (kind == FK_JUNK) begin
                    send_junk($urandom_range(4, 1), EXP_PREDICT);
                end else begin
                    for (ch = 0; ch < NUM_CH; ch++) smp[ch] = random_count(offs[ch]);
                    len = (kind == FK_CUT) ? $urandom_range(FRAME_BYTES - 1, 1) : FRAME_BYTES;
                    send_frame(build_frame(smp, kind), len, 1'b0, EXP_PREDICT);
                    counted += len;
                end
            end
        end

        // drain: let the receiver run free and wait out the last frame
        tx_rest();
        set_idling(0, 0);
        waited = 0;
        while (axis_expect_q.size() != 0 && waited < END_WAIT_CYCLES) begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (axis_expect_q.size() != 0) begin
            log_mismatch($sformatf("%0d axis results never arrived", axis_expect_q.size()));
        end

        $display("run took %0d byte requests: %0d frames decoded, %0d rejected at the checksum",
                 bytes_taken, frames_good, frames_bad);
        $display("checked %0d axis results over reset, zero, full-scale and random offsets",
                 axes_checked);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire
